FILE: sv/bgc_pkg.sv
// Shared types and constants of the button gesture classifier.
`default_nettype none
package bgc_pkg;

    localparam int unsigned TimeW   = 32;
    localparam int unsigned MsW     = 16;
    localparam int unsigned CountW  = 4;
    localparam int unsigned TallyW  = 8;
    localparam int unsigned SpanW   = MsW + CountW;
    localparam int unsigned CfgIdxW = 3;
    localparam int unsigned CfgW    = 16;
    localparam int unsigned InDataW  = 40;
    localparam int unsigned OutDataW = 8;

    // register indexes of the configuration port
    localparam logic [CfgIdxW-1:0] REG_SHORT_MAX    = 3'd0;
    localparam logic [CfgIdxW-1:0] REG_MEDIUM_HOLD  = 3'd1;
    localparam logic [CfgIdxW-1:0] REG_LONG_HOLD    = 3'd2;
    localparam logic [CfgIdxW-1:0] REG_MULTI_WINDOW = 3'd3;
    localparam logic [CfgIdxW-1:0] REG_MULTI_COUNT  = 3'd4;

    // reset values of the configuration registers
    localparam logic [MsW-1:0]    RST_SHORT_MAX    = 16'd2000;
    localparam logic [MsW-1:0]    RST_MEDIUM_HOLD  = 16'd2000;
    localparam logic [MsW-1:0]    RST_LONG_HOLD    = 16'd5000;
    localparam logic [MsW-1:0]    RST_MULTI_WINDOW = 16'd500;
    localparam logic [CountW-1:0] RST_MULTI_COUNT  = 4'd3;

    localparam logic [TallyW-1:0] TALLY_MAX = 8'hFF;

    typedef enum logic [1:0] {
        MODE_IDLE    = 2'd0,
        MODE_PRESSED = 2'd1,
        MODE_WAITING = 2'd2
    } t_mode;

    // one result beat
    typedef struct packed {
        logic keep_awake;
        logic multi_event;
        logic long_event;
        logic medium_event;
        logic short_event;
    } t_result;

endpackage
`default_nettype wire

FILE: sv/bgc_core.sv
// Gesture state, configuration registers and per-tick classification logic.
`default_nettype none
module bgc_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [bgc_pkg::CfgIdxW-1:0]    i_cfg_addr,
    input  wire logic [bgc_pkg::CfgW-1:0]       i_cfg_wdata,
    input  wire logic                           i_step,
    input  wire logic                           i_pressed,
    input  wire logic [bgc_pkg::TimeW-1:0]      i_now,
    output bgc_pkg::t_result                    o_result
);

    logic [bgc_pkg::MsW-1:0]    r_short_max;
    logic [bgc_pkg::MsW-1:0]    r_medium_hold;
    logic [bgc_pkg::MsW-1:0]    r_long_hold;
    logic [bgc_pkg::MsW-1:0]    r_multi_window;
    logic [bgc_pkg::CountW-1:0] r_multi_count;
    logic [bgc_pkg::SpanW-1:0]  r_span;

    logic                        r_last, n_last;
    bgc_pkg::t_mode              r_mode, n_mode;
    logic [bgc_pkg::TallyW-1:0]  r_tally, n_tally;
    logic [bgc_pkg::TimeW-1:0]   r_hold, n_hold;
    logic [bgc_pkg::TimeW-1:0]   r_release, n_release;
    logic [bgc_pkg::TimeW-1:0]   r_first, n_first;
    logic                        r_med_fired, n_med_fired;
    logic                        r_long_fired, n_long_fired;

    bgc_pkg::t_result c_ev;

    // configuration registers; span is re-registered from window and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_short_max    <= bgc_pkg::RST_SHORT_MAX;
            r_medium_hold  <= bgc_pkg::RST_MEDIUM_HOLD;
            r_long_hold    <= bgc_pkg::RST_LONG_HOLD;
            r_multi_window <= bgc_pkg::RST_MULTI_WINDOW;
            r_multi_count  <= bgc_pkg::RST_MULTI_COUNT;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_addr)
                bgc_pkg::REG_SHORT_MAX:    r_short_max    <= i_cfg_wdata;
                bgc_pkg::REG_MEDIUM_HOLD:  r_medium_hold  <= i_cfg_wdata;
                bgc_pkg::REG_LONG_HOLD:    r_long_hold    <= i_cfg_wdata;
                bgc_pkg::REG_MULTI_WINDOW: r_multi_window <= i_cfg_wdata;
                bgc_pkg::REG_MULTI_COUNT:  r_multi_count  <= i_cfg_wdata[bgc_pkg::CountW-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_span <= bgc_pkg::SpanW'(r_multi_window) * bgc_pkg::SpanW'(r_multi_count);
    end

    // next state
    always_comb begin
        logic [bgc_pkg::TimeW-1:0]  held;
        logic [bgc_pkg::TimeW-1:0]  span32;
        logic [bgc_pkg::TallyW-1:0] cnt8;
        logic                       go_idle;

        span32 = bgc_pkg::TimeW'(r_span);
        cnt8   = bgc_pkg::TallyW'(r_multi_count);
        held   = '0;
        go_idle = 1'b0;

        n_last       = i_pressed;
        n_mode       = r_mode;
        n_tally      = r_tally;
        n_hold       = r_hold;
        n_release    = r_release;
        n_first      = r_first;
        n_med_fired  = r_med_fired;
        n_long_fired = r_long_fired;
        c_ev         = '0;

        if (!r_last && i_pressed) begin
            n_mode       = bgc_pkg::MODE_PRESSED;
            n_hold       = i_now;
            n_med_fired  = 1'b0;
            n_long_fired = 1'b0;
            c_ev.short_event = 1'b1;
        end else if (r_last && !i_pressed) begin
            held      = i_now - r_hold;
            n_release = i_now;
            if (r_mode == bgc_pkg::MODE_PRESSED) begin
                if (held < bgc_pkg::TimeW'(r_short_max)) begin
                    if (r_tally != bgc_pkg::TALLY_MAX) begin
                        n_tally = r_tally + 8'd1;
                    end
                    if (n_tally == 8'd1) begin
                        n_first = i_now;
                        n_mode  = bgc_pkg::MODE_WAITING;
                    end else if (n_tally == cnt8) begin
                        if ((i_now - r_first) <= span32) begin
                            c_ev.multi_event = 1'b1;
                        end else begin
                            go_idle = 1'b1;
                        end
                    end else if (n_tally > cnt8) begin
                        if ((i_now - r_first) > span32) begin
                            go_idle = 1'b1;
                        end
                    end
                end else begin
                    go_idle = 1'b1;
                end
            end
        end

        if (go_idle) begin
            n_mode       = bgc_pkg::MODE_IDLE;
            n_tally      = '0;
            n_med_fired  = 1'b0;
            n_long_fired = 1'b0;
        end

        // hold thresholds: long takes priority on a given tick
        if (n_mode == bgc_pkg::MODE_PRESSED && i_pressed) begin
            held = i_now - n_hold;
            if (held >= bgc_pkg::TimeW'(r_long_hold) && !n_long_fired) begin
                c_ev.long_event = 1'b1;
                n_long_fired    = 1'b1;
            end else if (held >= bgc_pkg::TimeW'(r_medium_hold) && !n_med_fired) begin
                c_ev.medium_event = 1'b1;
                n_med_fired       = 1'b1;
            end
        end

        // wait timeout, checked on the entering tick too
        go_idle = 1'b0;
        if (n_mode == bgc_pkg::MODE_WAITING) begin
            if (n_tally >= cnt8) begin
                go_idle = (i_now - n_first) > span32;
            end else if (n_tally == 8'd1) begin
                go_idle = (i_now - n_release) > bgc_pkg::TimeW'(r_multi_window);
            end
        end
        if (go_idle) begin
            n_mode       = bgc_pkg::MODE_IDLE;
            n_tally      = '0;
            n_med_fired  = 1'b0;
            n_long_fired = 1'b0;
        end
    end

    // outputs
    always_comb begin
        o_result            = c_ev;
        o_result.keep_awake = i_pressed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last       <= 1'b0;
            r_mode       <= bgc_pkg::MODE_IDLE;
            r_tally      <= '0;
            r_hold       <= '0;
            r_release    <= '0;
            r_first      <= '0;
            r_med_fired  <= 1'b0;
            r_long_fired <= 1'b0;
        end else if (i_step) begin
            r_last       <= n_last;
            r_mode       <= n_mode;
            r_tally      <= n_tally;
            r_hold       <= n_hold;
            r_release    <= n_release;
            r_first      <= n_first;
            r_med_fired  <= n_med_fired;
            r_long_fired <= n_long_fired;
        end
    end

    a_short_not_multi: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> !(o_result.short_event && o_result.multi_event))
        else $error("short and multi events on one tick");

    a_long_not_medium: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step |-> !(o_result.long_event && o_result.medium_event))
        else $error("long and medium events on one tick");

    a_idle_tally_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mode == bgc_pkg::MODE_IDLE |-> r_tally == '0)
        else $error("press tally nonzero in idle mode");

    a_short_enters_pressed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_result.short_event |=> r_mode == bgc_pkg::MODE_PRESSED)
        else $error("press edge did not enter pressed mode");

endmodule
`default_nettype wire

FILE: sv/button_gesture_classifier.sv
// Top level of the button gesture classifier: stream ports, beat registers, core.
`default_nettype none
// Each input beat is one update tick: the debounced button level and a 32-bit
// millisecond timestamp (differences wrap modulo 2^32). Every tick yields
// exactly one output beat with four one-tick event flags (short on the press
// edge, medium and long when the hold reaches its threshold, multi when
// multi_count short presses complete within multi_window_ms * multi_count of
// the first release) plus keep_awake, a copy of the level. Throughput is one
// beat per clock while m_axis_tready does not stall it; a beat passes through
// the input register and then the result register around the single-pass
// classification logic. The output register lets a new beat in while a
// finished result waits. Writes to the window and count registers reach the
// multi-press span only once the span is re-registered from them.
module button_gesture_classifier (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [bgc_pkg::CfgIdxW-1:0]    i_cfg_addr,
    input  wire logic [bgc_pkg::CfgW-1:0]       i_cfg_wdata,
    input  wire logic                           s_axis_tvalid,
    output      logic                           s_axis_tready,
    // [0] pressed, [32:1] now_ms, [39:33] zero
    input  wire logic [bgc_pkg::InDataW-1:0]    s_axis_tdata,
    output      logic                           m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // [0] short_event, [1] medium_event, [2] long_event, [3] multi_event,
    // [4] keep_awake, [7:5] zero
    output      logic [bgc_pkg::OutDataW-1:0]   m_axis_tdata
);

    logic                         r_in_valid;
    logic                         r_in_pressed;
    logic [bgc_pkg::TimeW-1:0]    r_in_now;
    logic                         r_out_valid;
    bgc_pkg::t_result             r_out;
    bgc_pkg::t_result             w_result;
    logic                         w_step;

    // advance the held tick when the result register is free or draining
    assign w_step        = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // hold the input payload until it is classified
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_pressed <= s_axis_tdata[0];
            r_in_now     <= s_axis_tdata[bgc_pkg::TimeW:1];
        end
    end

    bgc_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (w_step),
        .i_pressed   (r_in_pressed),
        .i_now       (r_in_now),
        .o_result    (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out <= w_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = bgc_pkg::OutDataW'(r_out);

endmodule
`default_nettype wire
